### hdl/ip_acl_first_match_core_assert.svh
// Assertion macros shared by the ACL first-match core.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef IP_ACL_FIRST_MATCH_CORE_ASSERT_SVH
`define IP_ACL_FIRST_MATCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACL_FM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACL_FM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/acl_fm_pkg.sv
// Types and constants of the ACL first-match core.
// Used by acl_fm_match and ip_acl_first_match_core; no dependencies.
package acl_fm_pkg;

  localparam int OCTET_W = 9;
  localparam int ENTRY_W = 38;

  localparam logic [OCTET_W-1:0] WILDCARD_OCTET = 9'h1FF;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  localparam logic KIND_CONNECT = 1'b0;
  localparam logic KIND_BIND    = 1'b1;

  localparam logic [1:0] ADDR_RULE_COUNT = 2'd0;

  typedef struct packed {
    logic               permit;
    logic               kind;
    logic [OCTET_W-1:0] octet0;
    logic [OCTET_W-1:0] octet1;
    logic [OCTET_W-1:0] octet2;
    logic [OCTET_W-1:0] octet3;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic permit;
  } verdict_t;

endpackage

### hdl/ip_acl_first_match_core.sv
// First-match IPv4 access-control list: rule table in RAM, sequential scan.
// Depends on acl_fm_pkg, acl_fm_ram, acl_fm_match, ip_acl_first_match_core_assert.svh.
//
// Usage:
//   A transaction is taken when start is high and busy is low. in_req_type
//   selects a load (rule written to entry in_rule_index, no result) or a
//   check (in_cmd_kind plus in_query_ip scanned against the table).
//   busy stays low for a load. Loads to an index at or above
//   MAX_RULES are dropped.
//   A check scans entries 0 .. min(rule_count, MAX_RULES)-1, one entry per
//   cycle through the single RAM read port, and stops at the first hit or
//   after the last active entry. With a zero active count no scan runs and
//   the default deny is registered straight from the idle state. busy is
//   high from the cycle after a scanning check is taken until the result
//   shows; a new transaction may be taken in the cycle the result is on the
//   ports.
//   out_valid marks each result for one cycle; the receiver cannot stall.
//   rule_count is written over the APB port at byte address 0; write it
//   only while the block is idle. Reset clears rule_count and the control
//   state; the rule table is undefined until loaded.
module ip_acl_first_match_core #(
  parameter int MAX_RULES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [3:0]        in_rule_index,
  input  logic              in_rule_permit,
  input  logic              in_cmd_kind,
  input  logic signed [8:0] in_rule_octet0,
  input  logic signed [8:0] in_rule_octet1,
  input  logic signed [8:0] in_rule_octet2,
  input  logic signed [8:0] in_rule_octet3,
  input  logic [31:0]       in_query_ip,
  // result channel
  output logic              out_valid,
  output logic              out_passed,
  output logic              out_matched,
  output logic [3:0]        out_match_index,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int IW = (CW > 4) ? CW : 4;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0]         limit_r, limit_nxt;
  logic                  kind_r, kind_nxt;
  logic [31:0]           ip_r, ip_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_passed_r, out_passed_nxt;
  logic                  out_matched_r, out_matched_nxt;
  logic [3:0]            out_idx_r, out_idx_nxt;
  logic [4:0]            rule_count_r;

  logic                  accept;
  logic [LW-1:0]         count_ext;
  logic [CW-1:0]         active_limit;
  logic [CW-1:0]         next_idx;
  logic                  load_in_range;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  acl_fm_pkg::entry_t    ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [acl_fm_pkg::ENTRY_W-1:0] ram_rdata;
  acl_fm_pkg::entry_t    rd_entry;
  acl_fm_pkg::verdict_t  verdict;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr == acl_fm_pkg::ADDR_RULE_COUNT) ? {27'd0, rule_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= 5'd0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == acl_fm_pkg::ADDR_RULE_COUNT)) begin
      rule_count_r <= pwdata[4:0];
    end
  end

  // Saturate the active count to the table size.
  assign count_ext    = LW'(rule_count_r);
  assign active_limit = (count_ext > LW'(MAX_RULES)) ? CW'(MAX_RULES) : CW'(count_ext);

  // ---------------------------------------------------------------------
  // Rule table
  // ---------------------------------------------------------------------
  assign accept        = start && !busy;
  assign load_in_range = IW'(in_rule_index) < IW'(MAX_RULES);
  assign ram_we        = accept && (in_req_type == acl_fm_pkg::REQ_LOAD) && load_in_range;
  assign ram_waddr     = AW'(in_rule_index);

  assign ram_wdata.permit = in_rule_permit;
  assign ram_wdata.kind   = in_cmd_kind;
  assign ram_wdata.octet0 = in_rule_octet0;
  assign ram_wdata.octet1 = in_rule_octet1;
  assign ram_wdata.octet2 = in_rule_octet2;
  assign ram_wdata.octet3 = in_rule_octet3;

  acl_fm_ram #(
    .WIDTH (acl_fm_pkg::ENTRY_W),
    .DEPTH (MAX_RULES)
  ) u_rule_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = ram_rdata;

  acl_fm_match u_match (
    .entry   (rd_entry),
    .kind    (kind_r),
    .ip      (ip_r),
    .verdict (verdict)
  );

  // ---------------------------------------------------------------------
  // Scan control
  // ---------------------------------------------------------------------
  assign next_idx = cmp_idx_r + 1'b1;
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmp_idx_nxt     = cmp_idx_r;
    limit_nxt       = limit_r;
    kind_nxt        = kind_r;
    ip_nxt          = ip_r;
    out_valid_nxt   = 1'b0;
    out_passed_nxt  = out_passed_r;
    out_matched_nxt = out_matched_r;
    out_idx_nxt     = out_idx_r;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_req_type == acl_fm_pkg::REQ_CHECK)) begin
          kind_nxt  = in_cmd_kind;
          ip_nxt    = in_query_ip;
          limit_nxt = active_limit;
          if (active_limit == '0) begin
            // empty table: default deny right away
            out_valid_nxt   = 1'b1;
            out_passed_nxt  = 1'b0;
            out_matched_nxt = 1'b0;
            out_idx_nxt     = 4'd0;
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = '0;
            cmp_idx_nxt = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rdata holds entry cmp_idx_r; fetch the next one while comparing
        if (verdict.hit) begin
          out_valid_nxt   = 1'b1;
          out_passed_nxt  = verdict.permit;
          out_matched_nxt = 1'b1;
          out_idx_nxt     = 4'(cmp_idx_r);
          state_nxt       = ST_IDLE;
        end else if (next_idx == limit_r) begin
          out_valid_nxt   = 1'b1;
          out_passed_nxt  = 1'b0;
          out_matched_nxt = 1'b0;
          out_idx_nxt     = 4'd0;
          state_nxt       = ST_IDLE;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = AW'(next_idx);
          cmp_idx_nxt = next_idx;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmp_idx_r     <= cmp_idx_nxt;
    limit_r       <= limit_nxt;
    kind_r        <= kind_nxt;
    ip_r          <= ip_nxt;
    out_passed_r  <= out_passed_nxt;
    out_matched_r <= out_matched_nxt;
    out_idx_r     <= out_idx_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_passed      = out_passed_r;
  assign out_matched     = out_matched_r;
  assign out_match_index = out_idx_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "ip_acl_first_match_core_assert.svh"

  `ACL_FM_ASSERT_NXT(a_load_silent, accept && (in_req_type == acl_fm_pkg::REQ_LOAD), !out_valid, "load transaction produced a result")
  `ACL_FM_ASSERT_IMP(a_miss_zero, out_valid && !out_matched, !out_passed && (out_match_index == 4'd0), "default deny carries nonzero fields")
  `ACL_FM_ASSERT_IMP(a_done_idle, out_valid, !busy, "result shown while scan still running")
  `ACL_FM_ASSERT_NXT(a_scan_starts, accept && (in_req_type == acl_fm_pkg::REQ_CHECK) && (active_limit != '0), busy && !out_valid, "check with active rules did not start a scan")

endmodule

### hdl/acl_fm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module acl_fm_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### hdl/acl_fm_match.sv
// Compare one rule entry against a request kind and IPv4 address.
// Depends on acl_fm_pkg.
module acl_fm_match (
  input  acl_fm_pkg::entry_t   entry,
  input  logic                 kind,
  input  logic [31:0]          ip,
  output acl_fm_pkg::verdict_t verdict
);

  logic oct0_ok, oct1_ok, oct2_ok, oct3_ok;

  // A wildcard matches anything; other negative codes never match a byte.
  assign oct0_ok = (entry.octet0 == acl_fm_pkg::WILDCARD_OCTET) ||
                   (entry.octet0 == {1'b0, ip[31:24]});
  assign oct1_ok = (entry.octet1 == acl_fm_pkg::WILDCARD_OCTET) ||
                   (entry.octet1 == {1'b0, ip[23:16]});
  assign oct2_ok = (entry.octet2 == acl_fm_pkg::WILDCARD_OCTET) ||
                   (entry.octet2 == {1'b0, ip[15:8]});
  assign oct3_ok = (entry.octet3 == acl_fm_pkg::WILDCARD_OCTET) ||
                   (entry.octet3 == {1'b0, ip[7:0]});

  assign verdict.hit    = (entry.kind == kind) && oct0_ok && oct1_ok && oct2_ok && oct3_ok;
  assign verdict.permit = entry.permit;

endmodule

### tb/ip_acl_first_match_core_test.sv
// Testbench for ip_acl_first_match_core: directed and random rule loads and checks.
// Needs acl_fm_pkg and the core; verdicts are predicted by an in-bench rule table scan.
module ip_acl_first_match_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int SCAN_CYCLES = TABLE_DEPTH + 1;
  localparam int RANDOM_PER_SETTING = 95;

  typedef struct packed {
    logic       passed;
    logic       matched;
    logic [3:0] index;
  } acl_verdict_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [3:0]  in_rule_index;
  logic        in_rule_permit;
  logic        in_cmd_kind;
  logic [8:0]  in_rule_octet0;
  logic [8:0]  in_rule_octet1;
  logic [8:0]  in_rule_octet2;
  logic [8:0]  in_rule_octet3;
  logic [31:0] in_query_ip;
  logic        out_valid;
  logic        out_passed;
  logic        out_matched;
  logic [3:0]  out_match_index;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block's rule table and active count
  acl_fm_pkg::entry_t rule_shadow [TABLE_DEPTH];
  logic [4:0]         active_count;
  acl_verdict_t       pending_verdicts[$];

  int fail_count;
  int loads_sent;
  int checks_sent;
  int hits_predicted;
  int settings_used;
  bit quiet_sender;

  ip_acl_first_match_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_rule_index   (in_rule_index),
    .in_rule_permit  (in_rule_permit),
    .in_cmd_kind     (in_cmd_kind),
    .in_rule_octet0  (in_rule_octet0),
    .in_rule_octet1  (in_rule_octet1),
    .in_rule_octet2  (in_rule_octet2),
    .in_rule_octet3  (in_rule_octet3),
    .in_query_ip     (in_query_ip),
    .out_valid       (out_valid),
    .out_passed      (out_passed),
    .out_matched     (out_matched),
    .out_match_index (out_match_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("ip_acl_first_match_core test failed");
    $finish;
  end

  function automatic logic octet_hit(logic [8:0] rule_octet, logic [7:0] addr_octet);
    return rule_octet == acl_fm_pkg::WILDCARD_OCTET || rule_octet == {1'b0, addr_octet};
  endfunction

  // First entry of the same kind whose four octets all hit decides the verdict
  function automatic acl_verdict_t scan_rules(logic kind, logic [31:0] ip);
    acl_verdict_t       verdict;
    int                 limit;
    acl_fm_pkg::entry_t e;
    verdict = '0;
    limit = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
    for (int i = 0; i < limit; i++) begin
      e = rule_shadow[i];
      if (e.kind == kind && octet_hit(e.octet0, ip[31:24]) && octet_hit(e.octet1, ip[23:16])
          && octet_hit(e.octet2, ip[15:8]) && octet_hit(e.octet3, ip[7:0])) begin
        verdict.passed  = e.permit;
        verdict.matched = 1'b1;
        verdict.index   = 4'(i);
        break;
      end
    end
    return verdict;
  endfunction

  // Compare each result strobe with the oldest outstanding verdict
  always @(posedge clk) begin
    acl_verdict_t want;
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no check outstanding: passed=%0b matched=%0b index=%0d",
               out_passed, out_matched, out_match_index);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_passed !== want.passed) begin
          $error("passed: expected %0b, got %0b", want.passed, out_passed);
          fail_count++;
        end
        if (out_matched !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, out_matched);
          fail_count++;
        end
        if (out_match_index !== want.index) begin
          $error("match_index: expected %0d, got %0d", want.index, out_match_index);
          fail_count++;
        end
      end
    end
  end

  // Drive one transaction and hold it until taken; start stays high on return
  task automatic send_item(logic req, logic [3:0] idx, logic permit, logic kind,
                           logic [8:0] o0, logic [8:0] o1, logic [8:0] o2, logic [8:0] o3,
                           logic [31:0] ip);
    acl_verdict_t verdict;
    @(negedge clk);
    start          <= 1'b1;
    in_req_type    <= req;
    in_rule_index  <= idx;
    in_rule_permit <= permit;
    in_cmd_kind    <= kind;
    in_rule_octet0 <= o0;
    in_rule_octet1 <= o1;
    in_rule_octet2 <= o2;
    in_rule_octet3 <= o3;
    in_query_ip    <= ip;
    do @(posedge clk); while (busy);
    if (req == acl_fm_pkg::REQ_LOAD) begin
      rule_shadow[idx] = '{permit: permit, kind: kind, octet0: o0, octet1: o1,
                           octet2: o2, octet3: o3};
      loads_sent++;
    end else begin
      verdict = scan_rules(kind, ip);
      pending_verdicts.push_back(verdict);
      if (verdict.matched) hits_predicted++;
      checks_sent++;
    end
  endtask

  task automatic load_rule(logic [3:0] idx, logic permit, logic kind,
                           logic [8:0] o0, logic [8:0] o1, logic [8:0] o2, logic [8:0] o3);
    send_item(acl_fm_pkg::REQ_LOAD, idx, permit, kind, o0, o1, o2, o3, $urandom);
  endtask

  task automatic check_addr(logic kind, logic [31:0] ip);
    send_item(acl_fm_pkg::REQ_CHECK, 4'($urandom), 1'($urandom), kind, 9'($urandom),
              9'($urandom), 9'($urandom), 9'($urandom), ip);
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start, wait for every verdict, then let a full scan worth of cycles pass
  task automatic drain_results();
    hold_off(1);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES + 3) @(posedge clk);
  endtask

  task automatic set_rule_count(logic [4:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= acl_fm_pkg::ADDR_RULE_COUNT;
    pwdata  <= {27'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    active_count = value;
    settings_used++;
    // read back over a second transaction
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[4:0] !== value) begin
      $error("rule_count readback: expected %0d, got %0d", value, prdata[4:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_addr_octet();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd10;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [8:0] pick_rule_octet();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return acl_fm_pkg::WILDCARD_OCTET;
    if (roll < 50) return 9'($urandom_range(256, 510));
    return {1'b0, pick_addr_octet()};
  endfunction

  function automatic logic [31:0] pick_query_ip();
    if ($urandom_range(99) < 30) return $urandom;
    return {pick_addr_octet(), pick_addr_octet(), pick_addr_octet(), pick_addr_octet()};
  endfunction

  // Empty table scan: every check falls through to the default deny
  task automatic test_default_deny();
    set_rule_count(5'd0);
    check_addr(acl_fm_pkg::KIND_CONNECT, 32'h0000_0000);
    check_addr(acl_fm_pkg::KIND_BIND, 32'hFFFF_FFFF);
    drain_results();
  endtask

  // Order, kind filtering, wildcards, out-of-range octets and the count limit
  task automatic test_first_match_order();
    load_rule(4'd0, 1'b0, acl_fm_pkg::KIND_CONNECT, 9'd10, 9'd0, 9'd0, 9'd1);
    load_rule(4'd1, 1'b1, acl_fm_pkg::KIND_CONNECT, 9'd10, acl_fm_pkg::WILDCARD_OCTET,
              acl_fm_pkg::WILDCARD_OCTET, acl_fm_pkg::WILDCARD_OCTET);
    load_rule(4'd2, 1'b1, acl_fm_pkg::KIND_BIND, 9'd192, 9'd168, 9'd1,
              acl_fm_pkg::WILDCARD_OCTET);
    // negative octets other than the wildcard can never hit
    load_rule(4'd3, 1'b1, acl_fm_pkg::KIND_BIND, 9'h1FE, 9'h100, acl_fm_pkg::WILDCARD_OCTET,
              acl_fm_pkg::WILDCARD_OCTET);
    load_rule(4'd4, 1'b1, acl_fm_pkg::KIND_CONNECT, 9'd255, 9'd255, 9'd255, 9'd255);
    load_rule(4'd5, 1'b0, acl_fm_pkg::KIND_BIND, acl_fm_pkg::WILDCARD_OCTET,
              acl_fm_pkg::WILDCARD_OCTET, acl_fm_pkg::WILDCARD_OCTET,
              acl_fm_pkg::WILDCARD_OCTET);
    drain_results();
    set_rule_count(5'd6);
    check_addr(acl_fm_pkg::KIND_CONNECT, 32'h0A00_0001);
    check_addr(acl_fm_pkg::KIND_CONNECT, 32'h0A01_0203);
    check_addr(acl_fm_pkg::KIND_BIND, 32'hC0A8_014D);
    check_addr(acl_fm_pkg::KIND_BIND, 32'hFE00_0000);
    check_addr(acl_fm_pkg::KIND_BIND, 32'h0A00_0001);
    check_addr(acl_fm_pkg::KIND_CONNECT, 32'hFFFF_FFFF);
    check_addr(acl_fm_pkg::KIND_CONNECT, 32'h0B00_0000);
    drain_results();
    set_rule_count(5'd2);
    check_addr(acl_fm_pkg::KIND_BIND, 32'hC0A8_014D);
    drain_results();
  endtask

  // Only the last entry can hit; counts above the table size act as a full table
  task automatic test_count_saturation();
    for (int i = 0; i < TABLE_DEPTH - 1; i++)
      load_rule(4'(i), 1'($urandom), acl_fm_pkg::KIND_CONNECT, pick_rule_octet(),
                pick_rule_octet(), pick_rule_octet(), pick_rule_octet());
    load_rule(4'd15, 1'b1, acl_fm_pkg::KIND_BIND, 9'd1, 9'd2, 9'd3, 9'd4);
    drain_results();
    set_rule_count(5'd31);
    check_addr(acl_fm_pkg::KIND_BIND, 32'h0102_0304);
    drain_results();
    set_rule_count(5'd17);
    check_addr(acl_fm_pkg::KIND_BIND, 32'h0102_0304);
    drain_results();
    set_rule_count(5'd16);
    check_addr(acl_fm_pkg::KIND_BIND, 32'h0102_0304);
    drain_results();
    set_rule_count(5'd15);
    check_addr(acl_fm_pkg::KIND_BIND, 32'h0102_0304);
    drain_results();
  endtask

  // Mixed loads and checks under several active counts, with sender gaps
  task automatic test_random_traffic();
    logic [4:0] setting [6];
    setting = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd17, 5'd8};
    setting[5] = 5'($urandom_range(2, 15));
    for (int s = 0; s < 6; s++) begin
      set_rule_count(setting[s]);
      quiet_sender = (s == 0);
      for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
        if ($urandom_range(99) < 25)
          load_rule(4'($urandom), 1'($urandom), 1'($urandom), pick_rule_octet(),
                    pick_rule_octet(), pick_rule_octet(), pick_rule_octet());
        else
          check_addr(1'($urandom), pick_query_ip());
        if (!quiet_sender && $urandom_range(99) < 10) hold_off($urandom_range(1, 6));
        if ($urandom_range(99) < 2) drain_results();
      end
      drain_results();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_req_type    = acl_fm_pkg::REQ_LOAD;
    in_rule_index  = '0;
    in_rule_permit = 1'b0;
    in_cmd_kind    = acl_fm_pkg::KIND_CONNECT;
    in_rule_octet0 = '0;
    in_rule_octet1 = '0;
    in_rule_octet2 = '0;
    in_rule_octet3 = '0;
    in_query_ip    = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    active_count   = '0;
    fail_count     = 0;
    loads_sent     = 0;
    checks_sent    = 0;
    hits_predicted = 0;
    settings_used  = 0;
    quiet_sender   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_deny();
    test_first_match_order();
    test_count_saturation();
    test_random_traffic();
    drain_results();

    $display("Run covered %0d rule loads and %0d checks (%0d first-match hits, rest default deny)",
             loads_sent, checks_sent, hits_predicted);
    $display("across %0d rule_count settings, including zero, full table and saturated counts",
             settings_used);
    if (fail_count == 0)
      $display("ip_acl_first_match_core test passed");
    else
      $display("ip_acl_first_match_core test failed");
    $finish;
  end

endmodule
